// ===== rtl/ibus_frame_receiver_top_assert.svh =====
// assertion macros for the ibus frame receiver
`ifndef IBUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define IBUS_FRAME_RECEIVER_TOP_ASSERT_SVH

`define IBFR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ibfr invariant violated");

`define IBFR_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ibfr implication violated");

`endif

// ===== rtl/ibfr_pkg.sv =====
package ibfr_pkg;

	localparam int NumChannelsDefault = 14;

	localparam logic [7:0]  HdrFirst  = 8'h20;
	localparam logic [7:0]  HdrSecond = 8'h40;
	localparam logic [15:0] SumStart  = 16'hFFFF;
	localparam logic [15:0] SumInit   = SumStart - {8'h00, HdrFirst} - {8'h00, HdrSecond};

	localparam logic [15:0] ChanMinReset      = 16'd1000;
	localparam logic [15:0] ChanMaxReset      = 16'd2000;
	localparam logic [15:0] ClampMarginReset  = 16'd500;
	localparam logic [7:0]  FrameTimeoutReset = 8'd4;
	localparam logic [15:0] FailsafeReset     = 16'd21;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic KIND_CHANNEL  = 1'b0;
	localparam logic KIND_FAILSAFE = 1'b1;

	typedef enum logic [2:0] {
		REG_CHAN_MIN      = 3'd0,
		REG_CHAN_MAX      = 3'd1,
		REG_CLAMP_MARGIN  = 3'd2,
		REG_FRAME_TIMEOUT = 3'd3,
		REG_FAILSAFE      = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  channel_index;
		logic [15:0] channel_value;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] chan_min;
		logic [15:0] chan_max;
		logic [15:0] clamp_margin;
		logic [7:0]  frame_timeout_ticks;
		logic [15:0] failsafe_ticks;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR2,
		PH_COLLECT
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT,
		BK_FAIL
	} back_state_t;

endpackage

// ===== rtl/ibfr_ram.sv =====
module ibfr_ram #(
	parameter int Width = 16,
	parameter int Depth = 14,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ibfr_job_queue.sv =====
module ibfr_job_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                push_kind,
	input  logic                pop,
	output logic                head_kind,
	output ibfr_pkg::q_status_t status
);

	logic [1:0] kind_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= push_kind;
		end
	end

	assign head_kind    = kind_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

endmodule

// ===== rtl/ibfr_front.sv =====
module ibfr_front #(
	parameter int NumChannels = ibfr_pkg::NumChannelsDefault,
	localparam int DataBytes = 2 * NumChannels,
	localparam int PosW = $clog2(DataBytes + 2),
	localparam int AddrW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ibfr_pkg::in_item_t  in_data,
	input  ibfr_pkg::cfg_t      cfg,
	input  logic                back_busy,
	input  ibfr_pkg::q_status_t q_status,
	output logic                push,
	output logic                push_kind,
	output logic                ram_we,
	output logic [AddrW-1:0]    ram_waddr,
	output logic [15:0]         ram_wdata
);

	ibfr_pkg::phase_t phase_q, phase_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [15:0]     sum_q, sum_d;
	logic [7:0]      low_q, low_d;
	logic [7:0]      cks_low_q, cks_low_d;
	logic [7:0]      ht_q, ht_d;
	logic [15:0]     st_q, st_d;
	logic            lost_q, lost_d;

	logic        acc;
	logic        is_tick;
	logic [7:0]  b;
	logic        data_byte;
	logic        cks_low_byte;
	logic [7:0]  ht_inc;
	logic [15:0] st_inc;
	logic        timeout_hit;
	logic        fail_hit;
	logic        good;
	logic        stall;

	assign data_byte    = (pos_q < PosW'(DataBytes));
	assign cks_low_byte = (pos_q == PosW'(DataBytes));
	assign stall        = (phase_q == ibfr_pkg::PH_COLLECT) && data_byte && back_busy;
	assign in_ready     = !stall && !q_status.full;
	assign acc          = in_valid && in_ready;
	assign is_tick      = (in_data.action == ibfr_pkg::ACT_TICK);
	assign b            = in_data.rx_byte;

	assign ht_inc      = (ht_q == 8'hFF) ? ht_q : ht_q + 8'd1;
	assign st_inc      = (st_q == 16'hFFFF) ? st_q : st_q + 16'd1;
	assign timeout_hit = (ht_inc > cfg.frame_timeout_ticks);
	assign fail_hit    = !lost_q && (st_inc >= cfg.failsafe_ticks);
	assign good        = ({b, cks_low_q} == sum_q);

	assign ram_waddr = pos_q[AddrW:1];
	assign ram_wdata = {b, low_q};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			if (is_tick) begin
				if (phase_q != ibfr_pkg::PH_HUNT && timeout_hit) begin
					phase_d = ibfr_pkg::PH_HUNT;
				end
			end else begin
				case (phase_q)
					ibfr_pkg::PH_HUNT: begin
						if (b == ibfr_pkg::HdrFirst) begin
							phase_d = ibfr_pkg::PH_HDR2;
						end
					end
					ibfr_pkg::PH_HDR2: begin
						if (b == ibfr_pkg::HdrSecond) begin
							phase_d = ibfr_pkg::PH_COLLECT;
						end else if (b != ibfr_pkg::HdrFirst) begin
							phase_d = ibfr_pkg::PH_HUNT;
						end
					end
					ibfr_pkg::PH_COLLECT: begin
						if (!data_byte && !cks_low_byte) begin
							phase_d = ibfr_pkg::PH_HUNT;
						end
					end
					default: phase_d = ibfr_pkg::PH_HUNT;
				endcase
			end
		end
	end

	// datapath and outputs
	always_comb begin
		pos_d     = pos_q;
		sum_d     = sum_q;
		low_d     = low_q;
		cks_low_d = cks_low_q;
		ht_d      = ht_q;
		st_d      = st_q;
		lost_d    = lost_q;
		push      = 1'b0;
		push_kind = ibfr_pkg::KIND_CHANNEL;
		ram_we    = 1'b0;
		if (acc) begin
			if (is_tick) begin
				if (phase_q != ibfr_pkg::PH_HUNT) begin
					ht_d = ht_inc;
				end
				if (!lost_q) begin
					st_d = st_inc;
				end
				if (fail_hit) begin
					lost_d    = 1'b1;
					push      = 1'b1;
					push_kind = ibfr_pkg::KIND_FAILSAFE;
				end
			end else begin
				case (phase_q)
					ibfr_pkg::PH_HUNT: begin
						if (b == ibfr_pkg::HdrFirst) begin
							ht_d = 8'd0;
						end
					end
					ibfr_pkg::PH_HDR2: begin
						if (b == ibfr_pkg::HdrSecond) begin
							ht_d  = 8'd0;
							pos_d = '0;
							sum_d = ibfr_pkg::SumInit;
						end
					end
					ibfr_pkg::PH_COLLECT: begin
						if (data_byte) begin
							if (!pos_q[0]) begin
								low_d = b;
							end else begin
								ram_we = 1'b1;
							end
							sum_d = sum_q - {8'h00, b};
							pos_d = pos_q + PosW'(1);
						end else if (cks_low_byte) begin
							cks_low_d = b;
							pos_d     = pos_q + PosW'(1);
						end else begin
							pos_d = '0;
							if (good) begin
								lost_d    = 1'b0;
								st_d      = 16'd0;
								push      = 1'b1;
								push_kind = ibfr_pkg::KIND_CHANNEL;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ibfr_pkg::PH_HUNT;
			pos_q     <= '0;
			sum_q     <= ibfr_pkg::SumInit;
			cks_low_q <= 8'd0;
			ht_q      <= 8'd0;
			st_q      <= 16'd0;
			lost_q    <= 1'b1;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			cks_low_q <= cks_low_d;
			ht_q      <= ht_d;
			st_q      <= st_d;
			lost_q    <= lost_d;
		end
	end

	always_ff @(posedge clk) begin
		low_q <= low_d;
	end

endmodule

// ===== rtl/ibfr_back.sv =====
module ibfr_back #(
	parameter int NumChannels = ibfr_pkg::NumChannelsDefault,
	localparam int AddrW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ibfr_pkg::cfg_t      cfg,
	input  ibfr_pkg::q_status_t q_status,
	input  logic                head_kind,
	output logic                pop,
	output logic                busy,
	output logic                ram_re,
	output logic [AddrW-1:0]    ram_raddr,
	input  logic [15:0]         ram_rdata,
	output logic                out_valid,
	input  logic                out_ready,
	output ibfr_pkg::out_item_t out_data
);

	ibfr_pkg::back_state_t state_q, state_d;
	logic [AddrW-1:0]      ch_q;
	logic                  out_valid_q;
	ibfr_pkg::out_item_t   out_data_q;
	ibfr_pkg::out_item_t   load_item;
	logic                  load;
	logic                  slot_free;
	logic                  ch_last;

	function automatic logic [15:0] clamp_value(input logic [15:0] v, input ibfr_pkg::cfg_t c);
		logic signed [17:0] x;
		logic signed [17:0] lo_m;
		logic [16:0]        hi_m;
		logic [15:0]        r;
		x    = signed'({2'b00, v});
		lo_m = signed'({2'b00, c.chan_min}) - signed'({2'b00, c.clamp_margin});
		hi_m = {1'b0, c.chan_max} + {1'b0, c.clamp_margin};
		if (v == 16'd0) begin
			r = 16'd0;
		end else if (x < lo_m) begin
			r = 16'd0;
		end else if (v < c.chan_min) begin
			r = c.chan_min;
		end else if (v <= c.chan_max) begin
			r = v;
		end else if ({1'b0, v} < hi_m) begin
			r = c.chan_max;
		end else begin
			r = 16'd0;
		end
		return r;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign ch_last   = (ch_q == AddrW'(NumChannels - 1));
	assign busy      = (state_q != ibfr_pkg::BK_IDLE) || !q_status.empty;
	assign ram_raddr = ch_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ibfr_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = (head_kind == ibfr_pkg::KIND_FAILSAFE) ?
						ibfr_pkg::BK_FAIL : ibfr_pkg::BK_READ;
				end
			end
			ibfr_pkg::BK_READ: state_d = ibfr_pkg::BK_EMIT;
			ibfr_pkg::BK_EMIT: begin
				if (slot_free) begin
					state_d = ch_last ? ibfr_pkg::BK_IDLE : ibfr_pkg::BK_READ;
				end
			end
			ibfr_pkg::BK_FAIL: begin
				if (slot_free) begin
					state_d = ibfr_pkg::BK_IDLE;
				end
			end
			default: state_d = ibfr_pkg::BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		ram_re    = 1'b0;
		load      = 1'b0;
		load_item = '0;
		case (state_q)
			ibfr_pkg::BK_IDLE: pop = !q_status.empty;
			ibfr_pkg::BK_READ: ram_re = 1'b1;
			ibfr_pkg::BK_EMIT: begin
				load                    = slot_free;
				load_item.kind          = ibfr_pkg::KIND_CHANNEL;
				load_item.channel_index = 5'(ch_q);
				load_item.channel_value = clamp_value(ram_rdata, cfg);
				load_item.last          = ch_last;
			end
			ibfr_pkg::BK_FAIL: begin
				load           = slot_free;
				load_item.kind = ibfr_pkg::KIND_FAILSAFE;
				load_item.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ibfr_pkg::BK_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				ch_q <= '0;
			end else if (state_q == ibfr_pkg::BK_EMIT && slot_free && !ch_last) begin
				ch_q <= ch_q + AddrW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= load_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/ibus_frame_receiver_top.sv =====
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   in_data: action, rx_byte
// out      output     out_valid/out_ready out_data: kind, channel_index, channel_value, last
// cfg      input      cfg_we              cfg_index, cfg_wdata
//
// bytes and ticks are taken one per cycle while in_ready is high; the parser makes
// no wait of its own; a good frame drains as NumChannels results, each via a ram
// read and then the output register, after the job is popped off the queue; a
// failsafe result goes to the output register after that pop
// frame data bytes are held off while the previous burst still drains
// asynchronous active-low reset; payload ram has no clearing pass
`include "ibus_frame_receiver_top_assert.svh"

module ibus_frame_receiver_top #(
	parameter int NumChannels = ibfr_pkg::NumChannelsDefault,
	localparam int AddrW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ibfr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ibfr_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);

	ibfr_pkg::cfg_t      cfg_q;
	ibfr_pkg::q_status_t q_status;
	logic                job_push;
	logic                job_kind;
	logic                job_pop;
	logic                head_kind;
	logic                back_busy;
	logic                ram_we;
	logic [AddrW-1:0]    ram_waddr;
	logic [15:0]         ram_wdata;
	logic                ram_re;
	logic [AddrW-1:0]    ram_raddr;
	logic [15:0]         ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_min            <= ibfr_pkg::ChanMinReset;
			cfg_q.chan_max            <= ibfr_pkg::ChanMaxReset;
			cfg_q.clamp_margin        <= ibfr_pkg::ClampMarginReset;
			cfg_q.frame_timeout_ticks <= ibfr_pkg::FrameTimeoutReset;
			cfg_q.failsafe_ticks      <= ibfr_pkg::FailsafeReset;
		end else if (cfg_we) begin
			case (cfg_index)
				ibfr_pkg::REG_CHAN_MIN:      cfg_q.chan_min            <= cfg_wdata;
				ibfr_pkg::REG_CHAN_MAX:      cfg_q.chan_max            <= cfg_wdata;
				ibfr_pkg::REG_CLAMP_MARGIN:  cfg_q.clamp_margin        <= cfg_wdata;
				ibfr_pkg::REG_FRAME_TIMEOUT: cfg_q.frame_timeout_ticks <= cfg_wdata[7:0];
				ibfr_pkg::REG_FAILSAFE:      cfg_q.failsafe_ticks      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ibfr_front #(
		.NumChannels(NumChannels)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.back_busy(back_busy),
		.q_status (q_status),
		.push     (job_push),
		.push_kind(job_kind),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	ibfr_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_kind(job_kind),
		.pop      (job_pop),
		.head_kind(head_kind),
		.status   (q_status)
	);

	ibfr_ram #(
		.Width(16),
		.Depth(NumChannels)
	) u_payload_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ibfr_back #(
		.NumChannels(NumChannels)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.head_kind(head_kind),
		.pop      (job_pop),
		.busy     (back_busy),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	`IBFR_ASSERT_ALWAYS(a_no_push_when_full, !(job_push && q_status.full))
	`IBFR_ASSERT_ALWAYS(a_no_ram_collision, !(ram_we && ram_re))
	`IBFR_ASSERT_IMPLY(a_failsafe_shape, out_valid && out_data.kind == ibfr_pkg::KIND_FAILSAFE, out_data.last && out_data.channel_index == 5'd0 && out_data.channel_value == 16'd0)
	`IBFR_ASSERT_IMPLY(a_last_channel, out_valid && out_data.kind == ibfr_pkg::KIND_CHANNEL && out_data.last, out_data.channel_index == 5'(NumChannels - 1))

endmodule

// ===== tb/tb.sv =====
module tb;
	import ibfr_pkg::*;

	localparam int NUM_CH = NumChannelsDefault;
	localparam int DATA_BYTES = 2 * NUM_CH;
	localparam int SETTLE = 40;
	localparam int RANDOM_ITEMS = 80;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [2:0] REG_IDX_MAX = '1;

	typedef enum {ROW_CFG, ROW_FRAME, ROW_TICKS} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [2:0]  idx;
		logic [15:0] val;
		int          extra;
		int          hdr;
		int          ticks;
		int          cut;
		bit          corrupt;
		bit          sweep;
		bit          fixed;
		logic [15:0] fixed_val;
	} row_t;

	// channel words around the reset limits and what they clamp to
	localparam logic [15:0] EDGE_WORDS [NUM_CH] = '{
		16'd0, 16'hFFFF, 16'd1500, 16'd499, 16'd500, 16'd2000, 16'd2499,
		16'd2500, 16'd1000, 16'd1, 16'd999, 16'd2001, 16'd1999, 16'd501
	};
	localparam logic [15:0] EDGE_WANT [NUM_CH] = '{
		16'd0, 16'd0, 16'd1500, 16'd0, 16'd1000, 16'd2000, 16'd2000,
		16'd0, 16'd1000, 16'd0, 16'd1000, 16'd2000, 16'd1999, 16'd1000
	};

	localparam int SCRIPT_LEN = 17;

	row_t script [SCRIPT_LEN] = '{
		'{ROW_TICKS, REG_CHAN_MIN, 16'd0, 0, 0, 3, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_FRAME, REG_CHAN_MIN, 16'd0, 3, 0, 4, -1, 1'b0, 1'b1, 1'b1, 16'd0},
		'{ROW_FRAME, REG_CHAN_MIN, 16'd1200, 0, 0, 0, -1, 1'b1, 1'b0, 1'b0, 16'd0},
		'{ROW_FRAME, REG_CHAN_MIN, 16'd1200, 0, 0, 5, NUM_CH + 1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_TICKS, REG_CHAN_MIN, 16'd0, 0, 0, 20, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_FRAME_TIMEOUT, 16'd0, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_FRAME, REG_CHAN_MIN, 16'd1300, 0, 1, 0, 0, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_CHAN_MIN, 16'd3000, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_FRAME, REG_CHAN_MIN, 16'd2600, 0, 0, 0, -1, 1'b0, 1'b0, 1'b1, 16'd3000},
		'{ROW_CFG, REG_IDX_MAX, 16'd0, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_CHAN_MIN, 16'd0, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_CLAMP_MARGIN, 16'hFFFF, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_CHAN_MAX, 16'hFFFF, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_FAILSAFE, 16'd0, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, REG_FRAME_TIMEOUT, 16'd255, 0, 0, 0, -1, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_FRAME, REG_CHAN_MIN, 16'hFFFF, 0, 0, 9, -1, 1'b0, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_TICKS, REG_CHAN_MIN, 16'd0, 0, 0, 2, -1, 1'b0, 1'b0, 1'b0, 16'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	// predictor state
	cfg_t        shadow_cfg;
	phase_t      rx_phase = PH_HUNT;
	int          data_pos = 0;
	logic [7:0]  frame_bytes [DATA_BYTES];
	logic [15:0] sum_left = SumInit;
	logic [7:0]  sum_low_byte = '0;
	logic [7:0]  hdr_age = '0;
	logic [15:0] quiet_age = '0;
	bit          link_lost = 1'b1;

	out_item_t   results_due [$];
	logic [15:0] frame_words [NUM_CH];
	bit          typed_pending = 1'b0;
	logic [15:0] typed_words [NUM_CH];
	bit          no_idle = 1'b0;
	int          fed_items = 0;
	int          failures = 0;
	int          ready_hold = 0;

	always #6 clk = ~clk;

	ibus_frame_receiver_top #(
		.NumChannels(NUM_CH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	function automatic logic [15:0] clamp_channel(logic [15:0] v);
		int x, lo, hi, m;
		x = v;
		lo = shadow_cfg.chan_min;
		hi = shadow_cfg.chan_max;
		m = shadow_cfg.clamp_margin;
		if (x == 0) return 16'd0;
		if (x < lo - m) return 16'd0;
		if (x < lo) return shadow_cfg.chan_min;
		if (x <= hi) return v;
		if (x < hi + m) return shadow_cfg.chan_max;
		return 16'd0;
	endfunction

	task automatic decode_item(in_item_t it, ref out_item_t res [$]);
		logic [15:0] raw;
		if (it.action == ACT_TICK) begin
			if (rx_phase != PH_HUNT) begin
				if (hdr_age != 8'hFF) hdr_age++;
				if (hdr_age > shadow_cfg.frame_timeout_ticks) rx_phase = PH_HUNT;
			end
			if (!link_lost) begin
				if (quiet_age != 16'hFFFF) quiet_age++;
				if (quiet_age >= shadow_cfg.failsafe_ticks) begin
					link_lost = 1'b1;
					res.push_back(out_item_t'{kind: KIND_FAILSAFE, channel_index: 5'd0,
						channel_value: 16'd0, last: 1'b1});
				end
			end
			return;
		end
		case (rx_phase)
			PH_HUNT: begin
				if (it.rx_byte == HdrFirst) begin
					rx_phase = PH_HDR2;
					hdr_age = '0;
				end
			end
			PH_HDR2: begin
				if (it.rx_byte == HdrSecond) begin
					rx_phase = PH_COLLECT;
					hdr_age = '0;
					data_pos = 0;
					sum_left = SumInit;
				end else if (it.rx_byte != HdrFirst) begin
					rx_phase = PH_HUNT;
				end
			end
			default: begin
				if (data_pos < DATA_BYTES) begin
					frame_bytes[data_pos] = it.rx_byte;
					sum_left = sum_left - 16'(it.rx_byte);
					data_pos++;
				end else if (data_pos == DATA_BYTES) begin
					sum_low_byte = it.rx_byte;
					data_pos++;
				end else begin
					rx_phase = PH_HUNT;
					data_pos = 0;
					if ({it.rx_byte, sum_low_byte} == sum_left) begin
						link_lost = 1'b0;
						quiet_age = '0;
						for (int c = 0; c < NUM_CH; c++) begin
							raw = {frame_bytes[2 * c + 1], frame_bytes[2 * c]};
							res.push_back(out_item_t'{kind: KIND_CHANNEL, channel_index: 5'(c),
								channel_value: clamp_channel(raw), last: (c == NUM_CH - 1)});
						end
					end
				end
			end
		endcase
	endtask

	task automatic send_item(in_item_t it);
		out_item_t fresh [$];
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_item(it, fresh);
		foreach (fresh[k]) begin
			if (typed_pending && fresh[k].kind == KIND_CHANNEL)
				fresh[k].channel_value = typed_words[fresh[k].channel_index];
			results_due.push_back(fresh[k]);
		end
		fed_items++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(in_item_t'{action: ACT_BYTE, rx_byte: b});
	endtask

	task automatic send_tick();
		send_item(in_item_t'{action: ACT_TICK, rx_byte: 8'($urandom)});
	endtask

	// cut < 0 sends the whole frame, otherwise it stops before that byte
	task automatic send_frame(int extra_first, int hdr_ticks, int mid_ticks, bit corrupt, int cut);
		logic [15:0] sum;
		logic [7:0]  b;
		sum = SumInit;
		send_byte(HdrFirst);
		repeat (extra_first) send_byte(HdrFirst);
		repeat (hdr_ticks) send_tick();
		send_byte(HdrSecond);
		for (int k = 0; k < DATA_BYTES + 2; k++) begin
			if (k == cut) return;
			if (k == NUM_CH) repeat (mid_ticks) send_tick();
			if (k < DATA_BYTES) begin
				b = (k % 2) ? frame_words[k / 2][15:8] : frame_words[k / 2][7:0];
				sum = sum - 16'(b);
			end else begin
				if (k == DATA_BYTES && corrupt) sum = sum ^ 16'(1 << $urandom_range(0, 15));
				b = (k == DATA_BYTES) ? sum[7:0] : sum[15:8];
			end
			send_byte(b);
		end
	endtask

	task automatic wait_idle(int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CHAN_MIN:      shadow_cfg.chan_min = val;
			REG_CHAN_MAX:      shadow_cfg.chan_max = val;
			REG_CLAMP_MARGIN:  shadow_cfg.clamp_margin = val;
			REG_FRAME_TIMEOUT: shadow_cfg.frame_timeout_ticks = val[7:0];
			REG_FAILSAFE:      shadow_cfg.failsafe_ticks = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		int lo, hi, m;
		lo = shadow_cfg.chan_min;
		hi = shadow_cfg.chan_max;
		m = shadow_cfg.clamp_margin;
		case ($urandom_range(0, 11))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'(lo - m - 1);
			3: return 16'(lo - m);
			4: return 16'(lo - 1);
			5: return 16'(lo);
			6: return 16'(hi);
			7: return 16'(hi + 1);
			8: return 16'(hi + m - 1);
			9: return 16'(hi + m);
			10: return 16'($urandom_range(lo, hi));
			default: return 16'($urandom);
		endcase
	endfunction

	// result side: random backpressure and in-order compare
	always @(posedge clk) begin : collect_results
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: kind %0d channel_index %0d channel_value %0d last %0d",
						out_data.kind, out_data.channel_index, out_data.channel_value, out_data.last);
					failures++;
				end else begin
					want = results_due.pop_front();
					if (out_data.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, out_data.kind);
						failures++;
					end
					if (out_data.channel_index !== want.channel_index) begin
						$error("channel_index: expected %0d, actual %0d",
							want.channel_index, out_data.channel_index);
						failures++;
					end
					if (out_data.channel_value !== want.channel_value) begin
						$error("channel_value: expected %0d, actual %0d",
							want.channel_value, out_data.channel_value);
						failures++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, out_data.last);
						failures++;
					end
				end
				ready_hold = no_idle ? 0 : $urandom_range(0, 4);
			end else if (ready_hold > 0) begin
				ready_hold--;
			end
			out_ready <= (ready_hold == 0);
		end
	end

	initial begin
		int r;
		logic [2:0] idx;
		logic [15:0] val;
		shadow_cfg = '{chan_min: ChanMinReset, chan_max: ChanMaxReset,
			clamp_margin: ClampMarginReset, frame_timeout_ticks: FrameTimeoutReset,
			failsafe_ticks: FailsafeReset};
		foreach (frame_bytes[i]) frame_bytes[i] = '0;
		foreach (typed_words[i]) typed_words[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			case (script[i].op)
				ROW_CFG: begin
					wait_idle(SETTLE);
					write_reg(script[i].idx, script[i].val);
				end
				ROW_TICKS: repeat (script[i].ticks) send_tick();
				default: begin
					foreach (frame_words[c])
						frame_words[c] = script[i].sweep ? EDGE_WORDS[c] : script[i].val;
					foreach (typed_words[c])
						typed_words[c] = script[i].sweep ? EDGE_WANT[c] : script[i].fixed_val;
					typed_pending = script[i].fixed;
					send_frame(script[i].extra, script[i].hdr, script[i].ticks,
						script[i].corrupt, script[i].cut);
					typed_pending = 1'b0;
				end
			endcase
		end

		wait_idle(SETTLE);
		write_reg(REG_CHAN_MIN, ChanMinReset);
		write_reg(REG_CHAN_MAX, ChanMaxReset);
		write_reg(REG_CLAMP_MARGIN, ClampMarginReset);
		write_reg(REG_FRAME_TIMEOUT, 16'(FrameTimeoutReset));
		write_reg(REG_FAILSAFE, FailsafeReset);
		fed_items = 0;

		while (fed_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				wait_idle(SETTLE);
				repeat ($urandom_range(1, 3)) begin
					idx = ($urandom_range(0, 9) == 0) ? REG_IDX_MAX : 3'($urandom_range(0, 4));
					case (idx)
						REG_CHAN_MIN: val = ($urandom_range(0, 4) == 0) ?
							16'($urandom) : 16'($urandom_range(800, 1200));
						REG_CHAN_MAX: val = ($urandom_range(0, 4) == 0) ?
							16'($urandom) : 16'($urandom_range(1800, 2200));
						REG_CLAMP_MARGIN: val = ($urandom_range(0, 4) == 0) ?
							16'hFFFF : 16'($urandom_range(0, 1000));
						REG_FRAME_TIMEOUT: val = ($urandom_range(0, 4) == 0) ?
							16'd255 : 16'($urandom_range(0, 10));
						REG_FAILSAFE: val = ($urandom_range(0, 4) == 0) ?
							16'($urandom_range(0, 1) ? 16'hFFFF : 16'd0) : 16'($urandom_range(1, 40));
						default: val = 16'($urandom);
					endcase
					write_reg(idx, val);
				end
				no_idle = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 19);
			if (r < 14) begin
				foreach (frame_words[c]) frame_words[c] = pick_word();
				send_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
					($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6),
					(r >= 11 && r < 13),
					(r == 13) ? $urandom_range(0, DATA_BYTES + 1) : -1);
			end else if (r < 17) begin
				repeat ($urandom_range(1, 30)) send_tick();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: send_byte(HdrFirst);
						1: send_byte(HdrSecond);
						default: send_byte(8'($urandom));
					endcase
				end
			end
		end

		wait_idle(SETTLE);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ibfr_pkg.sv
rtl/ibfr_ram.sv
rtl/ibfr_job_queue.sv
rtl/ibfr_front.sv
rtl/ibfr_back.sv
rtl/ibus_frame_receiver_top.sv
tb/tb.sv
